>>> rtl/assert_macros.svh
// Assertion macros shared by the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue assertion failed");

`endif

>>> rtl/hpq_pkg.sv
// Shared constants, codes and types of the heap priority queue.
package hpq_pkg;

    localparam int HEAP_DEPTH  = 1024;
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 11;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0]    max_key;
        logic        [STATUS_W-1:0] status;
    } hpq_result_t;

endpackage

>>> rtl/hpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/hpq_seq.sv
// Sift sequencer of the heap queue: state machine, entry count and shared comparator.
`include "assert_macros.svh"

module hpq_seq #(
    parameter int DEPTH = hpq_pkg::HEAP_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_action,
    input  logic signed [hpq_pkg::KEY_W-1:0]  in_key,
    output logic                              res_valid,
    input  logic                              res_ready,
    output hpq_pkg::hpq_result_t              res,
    output logic [$clog2(DEPTH+1)-1:0]        count,
    output logic                              mem_we,
    output logic [$clog2(DEPTH)-1:0]          mem_waddr,
    output logic [hpq_pkg::KEY_W-1:0]         mem_wdata,
    output logic                              mem_re,
    output logic [$clog2(DEPTH)-1:0]          mem_raddr,
    input  logic [hpq_pkg::KEY_W-1:0]         mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int KW = hpq_pkg::KEY_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_CHK   = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_EX_ROOT  = 4'd3;
    localparam logic [3:0] S_EX_LAST  = 4'd4;
    localparam logic [3:0] S_DN_CHK   = 4'd5;
    localparam logic [3:0] S_DN_LEFT  = 4'd6;
    localparam logic [3:0] S_DN_RIGHT = 4'd7;
    localparam logic [3:0] S_DN_CMP   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]                   state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                pos_reg, pos_next;
    logic [CW-1:0]                best_pos_reg, best_pos_next;
    logic signed [KW-1:0]         val_reg, val_next;
    logic signed [KW-1:0]         best_reg, best_next;
    logic signed [KW-1:0]         max_reg, max_next;
    logic [hpq_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [CW-1:0]        pos_m1;
    logic [CW-1:0]        parent;
    logic [CW-1:0]        parent_m1;
    logic [CW:0]          left;
    logic [CW:0]          right;
    logic [CW:0]          left_m1;
    logic [CW:0]          count_ext;
    logic [CW-1:0]        count_m1;
    logic signed [KW-1:0] rdata_s;
    logic signed [KW-1:0] cmp_a;
    logic signed [KW-1:0] cmp_b;
    logic                 cmp_gt;
    logic                 at_chk;

    assign pos_m1    = pos_reg - CW'(1);
    assign parent    = pos_reg >> 1;
    assign parent_m1 = parent - CW'(1);
    assign left      = {pos_reg, 1'b0};
    assign right     = {pos_reg, 1'b1};
    assign left_m1   = left - (CW + 1)'(1);
    assign count_ext = {1'b0, count_reg};
    assign count_m1  = count_reg - CW'(1);
    assign rdata_s   = $signed(mem_rdata);
    assign at_chk    = state_reg == S_UP_CHK || state_reg == S_DN_CHK;

    // The one comparator; its operands are steered by the current step.
    always_comb
    begin
        unique case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = val_reg;
                cmp_b = rdata_s;
            end
            S_DN_RIGHT:
            begin
                cmp_a = rdata_s;
                cmp_b = best_reg;
            end
            default:
            begin
                cmp_a = best_reg;
                cmp_b = val_reg;
            end
        endcase
    end

    assign cmp_gt = cmp_a > cmp_b;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        best_pos_next = best_pos_reg;
        val_next      = val_reg;
        best_next     = best_reg;
        max_next      = max_reg;
        status_next   = status_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = pos_m1[AW-1:0];
        mem_wdata     = val_reg;
        mem_re        = 1'b0;
        mem_raddr     = left_m1[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    max_next    = '0;
                    status_next = hpq_pkg::ST_OK;
                    pos_next    = CW'(1);
                    if (in_action == hpq_pkg::ACT_INSERT)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = hpq_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            pos_next   = count_reg + CW'(1);
                            val_next   = in_key;
                            state_next = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = hpq_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            state_next = S_EX_ROOT;
                        end
                    end
                end
            end
            S_UP_CHK:
            begin
                if (pos_reg == CW'(1))
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = parent_m1[AW-1:0];
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_gt)
                begin
                    // The parent moves down into the hole and the hole climbs.
                    mem_wdata  = mem_rdata;
                    pos_next   = parent;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EX_ROOT:
            begin
                max_next   = rdata_s;
                mem_re     = 1'b1;
                mem_raddr  = count_m1[AW-1:0];
                count_next = count_m1;
                state_next = S_EX_LAST;
            end
            S_EX_LAST:
            begin
                val_next   = rdata_s;
                pos_next   = CW'(1);
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (left > count_ext)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_DN_LEFT;
                end
            end
            S_DN_LEFT:
            begin
                best_next     = rdata_s;
                best_pos_next = left[CW-1:0];
                if (right <= count_ext)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = left[AW-1:0];
                    state_next = S_DN_RIGHT;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_RIGHT:
            begin
                // The right child wins only when strictly larger.
                if (cmp_gt)
                begin
                    best_next     = rdata_s;
                    best_pos_next = right[CW-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_gt)
                begin
                    mem_wdata  = best_reg;
                    pos_next   = best_pos_reg;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        best_pos_reg <= best_pos_next;
        val_reg      <= val_next;
        best_reg     <= best_next;
        max_reg      <= max_next;
        status_reg   <= status_next;
    end

    assign res.max_key = max_reg;
    assign res.status  = status_reg;
    assign count       = count_reg;

    `ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(DEPTH))
    `ASSERT_NOW(a_port_excl, mem_we, !mem_re)
    `ASSERT_NOW(a_pos_valid, at_chk, pos_reg != '0 && pos_reg <= CW'(DEPTH))

endmodule

>>> rtl/binary_max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue with its stream ports.
//
// Input beats arrive on the s_axis group: tuser carries the action (insert
// or extract maximum) and tdata carries the signed key, used only by insert.
// Each input beat yields exactly one output beat on the m_axis group with
// the extracted key (zero unless an extract succeeded), a status code and
// the number of keys held after the item.
// Keys live in a single-port-read RAM; one comparator and a small state
// machine sift the moving key one level at a time, paced by the memory
// read port, one read per cycle. The block takes one item at a time and
// raises s_axis_tready again once the result has moved to the output
// register.
// Reset empties the queue at once; the RAM needs no clearing pass since
// only entries below the count are ever read.
// When the receiver stalls, the output beat is held in its register and the
// next result waits in the sequencer, so no beat is lost or repeated.
`include "assert_macros.svh"

module binary_max_heap_priority_queue #(
    parameter int HEAP_DEPTH = hpq_pkg::HEAP_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: key[31:0].
    input  logic [hpq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: action[0].
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: max_key[31:0], status[33:32], occupancy[44:34], zero fill[47:45].
    output logic [hpq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int KW = hpq_pkg::KEY_W;
    localparam int OW = hpq_pkg::OCC_W;
    localparam int PW = hpq_pkg::OUT_TDATA_W - KW - hpq_pkg::STATUS_W - OW;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [KW-1:0]        mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [KW-1:0]        mem_rdata;
    logic                 res_valid;
    logic                 res_ready;
    hpq_pkg::hpq_result_t res;
    logic [CW-1:0]        count;

    logic                               out_valid_reg;
    logic [hpq_pkg::OUT_TDATA_W-1:0]    out_data_reg;

    hpq_ram #(
        .WIDTH (KW),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hpq_seq #(
        .DEPTH (HEAP_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_key    ($signed(s_axis_tdata)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .count     (count),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // The output register frees whenever its beat is taken.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= {PW'(0), OW'(count), res.status, res.max_key};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
